[src/assert_macros.svh]
// Assertion macros for the positional array list RTL.
// Self-contained; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PAL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define PAL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/pal_pkg.sv]
// Package for the positional array list: sizes, codes and beat structs.
// Used by pal_mem, pal_ctrl and positional_array_list_unit.
package pal_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int POS_W       = 7;

   // Request kinds.
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_REPLACE = 2'd2,
      OP_SEARCH  = 2'd3
   } pal_op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_POS   = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } pal_status_type;

   typedef struct packed {
      pal_op_type               req_type;
      logic [POS_W-1:0]         position;
      logic signed [VALUE_WIDTH-1:0] value;
   } pal_req_type;

   typedef struct packed {
      pal_status_type   status;
      logic [POS_W-1:0] found_index;
      logic [CNT_W-1:0] list_length;
   } pal_rsp_type;

   // Access to the entry memory for one cycle.
   typedef struct packed {
      logic                   we;
      logic [IDX_W-1:0]       waddr;
      logic [VALUE_WIDTH-1:0] wdata;
      logic                   re;
      logic [IDX_W-1:0]       raddr;
   } pal_mem_req_type;

endpackage

[src/pal_mem.sv]
// Entry store of the list: one write port, one read port, registered read data.
// Depends on pal_pkg for sizes and the access struct.
module pal_mem import pal_pkg::*; (
   input  logic                   clock,
   input  pal_mem_req_type        mem_req,
   output logic [VALUE_WIDTH-1:0] rdata
);

   logic [VALUE_WIDTH-1:0] entries_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         entries_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rdata_ff <= entries_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/pal_ctrl.sv]
// Sequencer of the positional array list: checks requests, walks the entry
// memory for shifts and searches, keeps the length. Depends on pal_pkg.
module pal_ctrl import pal_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pal_req_type            req_beat,
   output logic                   rsp_strobe,
   output pal_rsp_type            rsp_beat,
   output pal_mem_req_type        mem_req,
   input  logic [VALUE_WIDTH-1:0] mem_rdata
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_MOVE   = 5'b00010,
      S_PUT    = 5'b00100,
      S_SEARCH = 5'b01000,
      S_DONE   = 5'b10000
   } pal_state_type;

   pal_state_type          state_ff, state_in;
   pal_op_type             op_ff, op_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       src_ff, src_in;
   logic [IDX_W-1:0]       dst_ff, dst_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic                   pend_ff, pend_in;
   pal_status_type         status_ff, status_in;
   logic [POS_W-1:0]       found_ff, found_in;

   logic [CNT_W-1:0]       req_pos;
   logic [CNT_W-1:0]       cur_pos;

   assign req_pos = CNT_W'(req_beat.position);
   assign cur_pos = CNT_W'(pos_ff);

   // Next state, memory access and result bookkeeping.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      left_in   = left_ff;
      pend_in   = 1'b0;
      status_in = status_ff;
      found_in  = found_ff;
      mem_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_beat.req_type;
               pos_in    = req_beat.position;
               val_in    = req_beat.value;
               found_in  = '0;
               status_in = STAT_OK;
               state_in  = S_DONE;
               unique case (req_beat.req_type)
                  OP_INSERT: begin
                     if (req_pos == '0 || req_pos > count_ff + CNT_W'(1)) begin
                        status_in = STAT_BAD_POS;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        // Entries pos-1 .. count-1 move up by one, top first.
                        left_in  = count_ff - req_pos + CNT_W'(1);
                        src_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in = (count_ff >= req_pos) ? S_MOVE : S_PUT;
                     end
                  end
                  OP_DELETE: begin
                     if (req_pos == '0 || req_pos > count_ff) begin
                        status_in = STAT_BAD_POS;
                     end else if (count_ff > req_pos) begin
                        // Entries pos .. count-1 move down by one, bottom first.
                        left_in  = count_ff - req_pos;
                        src_in   = req_pos[IDX_W-1:0];
                        state_in = S_MOVE;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_REPLACE: begin
                     if (req_pos == '0 || req_pos > count_ff) begin
                        status_in = STAT_BAD_POS;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = IDX_W'(req_pos - CNT_W'(1));
                        mem_req.wdata = req_beat.value;
                     end
                  end
                  OP_SEARCH: begin
                     status_in = STAT_NOT_FOUND;
                     left_in   = count_ff;
                     src_in    = '0;
                     if (count_ff != '0) begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // One read and one write per cycle; the read of one entry is written
         // back to its neighbor in the next cycle, so the two never meet.
         S_MOVE: begin
            if (pend_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = dst_ff;
               mem_req.wdata = mem_rdata;
            end
            if (left_ff != '0) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = src_ff;
               pend_in       = 1'b1;
               left_in       = left_ff - CNT_W'(1);
               if (op_ff == OP_INSERT) begin
                  dst_in = src_ff + IDX_W'(1);
                  src_in = src_ff - IDX_W'(1);
               end else begin
                  dst_in = src_ff - IDX_W'(1);
                  src_in = src_ff + IDX_W'(1);
               end
            end else if (op_ff == OP_INSERT) begin
               state_in = S_PUT;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         // The new value lands at its position: in the gap opened by the shift, or past the last entry.
         S_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = IDX_W'(cur_pos - CNT_W'(1));
            mem_req.wdata = val_ff;
            count_in      = count_ff + CNT_W'(1);
            state_in      = S_DONE;
         end

         // Read entries from the bottom and compare each in the next cycle.
         S_SEARCH: begin
            if (pend_ff && mem_rdata == val_ff) begin
               found_in  = POS_W'({1'b0, dst_ff}) + POS_W'(1);
               status_in = STAT_OK;
               state_in  = S_DONE;
            end else if (left_ff == '0) begin
               state_in = S_DONE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = src_ff;
               pend_in       = 1'b1;
               dst_in        = src_ff;
               src_in        = src_ff + IDX_W'(1);
               left_in       = left_ff - CNT_W'(1);
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = (state_ff == S_DONE);
   assign rsp_beat.status      = status_ff;
   assign rsp_beat.found_index = found_ff;
   assign rsp_beat.list_length = count_ff;

endmodule

[src/positional_array_list_unit.sv]
// Positional array list: an ordered list of up to 64 signed 32-bit words with
// insert, delete, replace and search by 1-based position, built on pal_ctrl and
// pal_mem from pal_pkg. A request beat is taken when start is high and busy is
// low; its single result beat appears on rsp_beat for exactly one cycle with
// rsp_strobe high and cannot be held off. Errors and replace go straight to the
// result; insert moves n = length-position+1 entries up and then writes the new
// value; delete moves n = length-position entries down and then updates the
// length; search reads and compares the entries from the bottom until a match
// or the end of the list. The entry memory moves or compares one entry a cycle
// through its single read and single write port. busy drops the cycle after
// the result, and the next request can be taken then.
`include "assert_macros.svh"

module positional_array_list_unit import pal_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  pal_req_type req_beat,
   output logic        rsp_strobe,
   output pal_rsp_type rsp_beat
);

   pal_mem_req_type        mem_req;
   logic [VALUE_WIDTH-1:0] mem_rdata;

   // Sequencer.
   pal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_beat   (req_beat),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   // Entry memory.
   pal_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   // Checks on the request and result sides.
   `PAL_ASSERT(a_len_cap, clock, reset, rsp_strobe |-> (rsp_beat.list_length <= CAPACITY), "list length above capacity")
   `PAL_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe, "result strobe held for two cycles")
   `PAL_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted beat did not raise busy")
   `PAL_ASSERT(a_found_ok, clock, reset, (rsp_strobe && (rsp_beat.found_index != '0)) |-> (rsp_beat.status == STAT_OK), "found index given without ok status")

endmodule
